// ===== hdl/crc8fc_pkg.sv =====
// Types, constants and the CRC byte update for the CRC-8 frame checker.
package crc8fc_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [7:0] HDR_FIRST       = 8'hAA;
   localparam logic [7:0] HDR_SECOND      = 8'h55;
   localparam logic [7:0] CRC_TOP_BIT     = 8'h80;
   localparam logic [7:0] MIN_FRAME_BYTES = 8'd5;
   localparam logic [7:0] COUNT_MAX       = 8'hFF;
   localparam logic [7:0] POLY_RESET      = 8'h07;

   localparam logic [0:0] REG_CRC_POLYNOMIAL = 1'b0;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_SHORT  = 3'd1;
   localparam logic [2:0] ST_HEADER = 3'd2;
   localparam logic [2:0] ST_LENGTH = 3'd3;
   localparam logic [2:0] ST_CRC    = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] frame_length;
   } rsp_payload_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP_BIT) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== hdl/crc8_frame_checker.sv =====
// CRC-8 frame checker: byte stream in, one status beat per frame out.
//
//   channel  direction  handshake                  payload
//   req      in         req_valid / req_stall      data_byte, last
//   rsp      out        rsp_valid / rsp_stall      status, frame_length
//   csr      in         APB psel/penable/pwrite    crc_polynomial at address 0
//
// One byte is accepted per cycle while req_stall is low; the CRC update is
// one unrolled 8-bit step that feeds the CRC register back into itself.
// A frame's status beat appears in the cycle after its last byte is accepted.
// req_stall rises only while a status beat is held and rsp_stall is high.
// Reset is synchronous; it clears the frame state and sets the polynomial to 7.
module crc8_frame_checker (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  crc8fc_pkg::req_payload_type                 req_payload,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output crc8fc_pkg::rsp_payload_type                 rsp_payload,
   input  logic                                        csr_psel,
   input  logic                                        csr_penable,
   input  logic                                        csr_pwrite,
   input  logic [crc8fc_pkg::CSR_ADDR_WIDTH-1:0]       csr_paddr,
   input  logic [crc8fc_pkg::CSR_DATA_WIDTH-1:0]       csr_pwdata,
   output logic [crc8fc_pkg::CSR_DATA_WIDTH-1:0]       csr_prdata,
   output logic                                        csr_pready
);

   logic [7:0]                  poly_ff, poly_in;
   logic [7:0]                  byte_count_ff, byte_count_in;
   logic [7:0]                  crc_ff, crc_in;
   logic                        header_bad_ff, header_bad_in;
   logic [7:0]                  decl_len_ff, decl_len_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   crc8fc_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic       req_accept;
   logic       csr_write;
   logic [0:0] csr_index;
   logic [7:0] count;
   logic [2:0] status;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_index == crc8fc_pkg::REG_CRC_POLYNOMIAL) ?
                       {{(crc8fc_pkg::CSR_DATA_WIDTH-8){1'b0}}, poly_ff} :
                       '0;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      poly_in = poly_ff;
      if (csr_write && csr_index == crc8fc_pkg::REG_CRC_POLYNOMIAL) begin
         poly_in = csr_pwdata[7:0];
      end
   end

   always_comb begin
      header_bad_in = header_bad_ff;
      if (byte_count_ff == 8'd0 && req_payload.data_byte != crc8fc_pkg::HDR_FIRST) begin
         header_bad_in = 1'b1;
      end
      if (byte_count_ff == 8'd1 && req_payload.data_byte != crc8fc_pkg::HDR_SECOND) begin
         header_bad_in = 1'b1;
      end
      decl_len_in = (byte_count_ff == 8'd2) ? req_payload.data_byte : decl_len_ff;
      count = (byte_count_ff == crc8fc_pkg::COUNT_MAX) ? crc8fc_pkg::COUNT_MAX :
              byte_count_ff + 8'd1;

      if (count < crc8fc_pkg::MIN_FRAME_BYTES) begin
         status = crc8fc_pkg::ST_SHORT;
      end else if (header_bad_in) begin
         status = crc8fc_pkg::ST_HEADER;
      end else if (decl_len_in[7] || decl_len_in != count) begin
         status = crc8fc_pkg::ST_LENGTH;
      end else if (req_payload.data_byte != crc_ff) begin
         status = crc8fc_pkg::ST_CRC;
      end else begin
         status = crc8fc_pkg::ST_OK;
      end

      crc_in        = crc8fc_pkg::crc8_byte(crc_ff, req_payload.data_byte, poly_ff);
      byte_count_in = count;
      if (req_payload.last) begin
         crc_in        = 8'd0;
         byte_count_in = 8'd0;
         header_bad_in = 1'b0;
         decl_len_in   = 8'd0;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (req_accept) begin
         rsp_valid_in = req_payload.last;
         if (req_payload.last) begin
            rsp_payload_in.status       = status;
            rsp_payload_in.frame_length = count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff       <= crc8fc_pkg::POLY_RESET;
         byte_count_ff <= 8'd0;
         crc_ff        <= 8'd0;
         header_bad_ff <= 1'b0;
         decl_len_ff   <= 8'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         poly_ff      <= poly_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            byte_count_ff <= byte_count_in;
            crc_ff        <= crc_in;
            header_bad_ff <= header_bad_in;
            decl_len_ff   <= decl_len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no status beat held");

   a_beat_follows_last: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid == $past(req_payload.last))
      else $error("status beat does not match the last flag of the accepted byte");

   a_frame_state_cleared: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_payload.last) |=>
         (byte_count_ff == 8'd0 && crc_ff == 8'd0 && !header_bad_ff && decl_len_ff == 8'd0))
      else $error("frame state not cleared after last byte");

   a_ok_has_min_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == crc8fc_pkg::ST_OK) |->
         (rsp_payload.frame_length >= crc8fc_pkg::MIN_FRAME_BYTES &&
          rsp_payload.frame_length[7] == 1'b0))
      else $error("ok status on a frame of impossible length");

endmodule

// ===== verif/tb_crc8_frame_checker.sv =====
// Testbench for the CRC-8 frame checker: directed frames, then random frames under varied idling.
`timescale 1ns / 1ps

module tb_crc8_frame_checker;

   localparam logic [crc8fc_pkg::CSR_ADDR_WIDTH-1:0] POLY_ADDR =
      {crc8fc_pkg::REG_CRC_POLYNOMIAL, 2'b00};
   localparam int unsigned BEATS_PER_PHASE = 185;
   localparam int unsigned LONG_HOLD_CYCLES = 150;

   typedef struct {
      logic [7:0] data_byte;
      logic       last;
      bit         use_crc;
      bit         bad_crc;
      bit         typed;
      logic [2:0] status;
      logic [7:0] frame_length;
   } frame_row_type;

   logic                                  clock;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   crc8fc_pkg::req_payload_type           req_payload = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   crc8fc_pkg::rsp_payload_type           rsp_payload;
   logic                                  csr_psel = 1'b0;
   logic                                  csr_penable = 1'b0;
   logic                                  csr_pwrite = 1'b0;
   logic [crc8fc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [crc8fc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [crc8fc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                                  csr_pready;

   // frame state tracked alongside the block
   logic [7:0] crc_poly = crc8fc_pkg::POLY_RESET;
   logic [7:0] seen_bytes = '0;
   logic [7:0] frame_crc = '0;
   logic       hdr_bad = 1'b0;
   logic [7:0] decl_len = '0;

   crc8fc_pkg::rsp_payload_type status_due_q [$];
   crc8fc_pkg::rsp_payload_type want;

   int unsigned sender_gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned fail_count = 0;
   int unsigned csr_fail_count = 0;
   int unsigned beats_sent = 0;
   int unsigned frames_done = 0;
   int unsigned poly_settings = 1;
   int unsigned status_seen [0:7] = '{default: 0};

   frame_row_type frame_rows [0:24] = '{
      '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, crc8fc_pkg::ST_SHORT,  8'd1},
      '{8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h55, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h04, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h00, 1'b1, 1'b0, 1'b0, 1'b1, crc8fc_pkg::ST_SHORT,  8'd4},
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h55, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h05, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h00, 1'b1, 1'b0, 1'b0, 1'b1, crc8fc_pkg::ST_HEADER, 8'd5},
      '{8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h55, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h05, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h3C, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h55, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h00, 1'b1, 1'b0, 1'b0, 1'b1, crc8fc_pkg::ST_LENGTH, 8'd5},
      '{8'hAA, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h55, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h05, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'hC3, 1'b0, 1'b0, 1'b0, 1'b0, crc8fc_pkg::ST_OK,     8'd0},
      '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0, crc8fc_pkg::ST_OK,     8'd0}
   };

   crc8_frame_checker i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [7:0] crc_shift_in(input logic [7:0] crc, input logic [7:0] d,
                                               input logic [7:0] poly);
      logic [7:0] acc;
      logic       fb;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = acc[7] ^ d[i];
         acc = {acc[6:0], 1'b0} ^ (fb ? poly : 8'h00);
      end
      return acc;
   endfunction

   task automatic absorb_byte(input crc8fc_pkg::req_payload_type p, output bit done,
                              output crc8fc_pkg::rsp_payload_type r);
      logic [7:0] cnt;
      if (seen_bytes == 8'd0 && p.data_byte != crc8fc_pkg::HDR_FIRST) hdr_bad = 1'b1;
      if (seen_bytes == 8'd1 && p.data_byte != crc8fc_pkg::HDR_SECOND) hdr_bad = 1'b1;
      if (seen_bytes == 8'd2) decl_len = p.data_byte;
      cnt = (seen_bytes == crc8fc_pkg::COUNT_MAX) ? crc8fc_pkg::COUNT_MAX :
            seen_bytes + 8'd1;
      r = '0;
      done = p.last;
      if (!p.last) begin
         frame_crc = crc_shift_in(frame_crc, p.data_byte, crc_poly);
         seen_bytes = cnt;
      end else begin
         r.frame_length = cnt;
         if (cnt < crc8fc_pkg::MIN_FRAME_BYTES) r.status = crc8fc_pkg::ST_SHORT;
         else if (hdr_bad) r.status = crc8fc_pkg::ST_HEADER;
         else if (decl_len[7] || decl_len != cnt) r.status = crc8fc_pkg::ST_LENGTH;
         else if (p.data_byte != frame_crc) r.status = crc8fc_pkg::ST_CRC;
         else r.status = crc8fc_pkg::ST_OK;
         seen_bytes = '0;
         frame_crc = '0;
         hdr_bad = 1'b0;
         decl_len = '0;
      end
   endtask

   // entered and left at a falling edge; valid stays up for back-to-back beats
   task automatic send_beat(input logic [7:0] d, input logic l, input bit typed,
                            input crc8fc_pkg::rsp_payload_type typed_rsp);
      crc8fc_pkg::req_payload_type p;
      crc8fc_pkg::rsp_payload_type r;
      bit                          done;
      p.data_byte = d;
      p.last = l;
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_byte(p, done, r);
      if (done) begin
         status_due_q.insert(status_due_q.size(), typed ? typed_rsp : r);
         frames_done++;
      end
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input int unsigned force_len);
      int unsigned pick;
      int unsigned n;
      int unsigned bad_pos;
      bit          good_crc;
      bit          formed;
      logic [7:0]  d;
      pick = $urandom_range(99);
      good_crc = ($urandom_range(9) < 8) || (force_len != 0);
      bad_pos = 99;
      if (force_len != 0) n = force_len;
      else if (pick < 60) n = $urandom_range(5, 20);
      else if (pick < 68) n = $urandom_range(21, 127);
      else if (pick < 70) n = $urandom_range(128, 300);
      else if (pick < 78) n = $urandom_range(1, 4);
      else n = $urandom_range(5, 20);
      if (force_len == 0 && pick >= 78 && pick < 88) bad_pos = $urandom_range(1);
      formed = (force_len != 0) || pick < 70 || (pick >= 78 && pick < 88);
      for (int unsigned i = 0; i < n; i++) begin
         d = 8'($urandom);
         if (formed) begin
            if (i == 0) d = crc8fc_pkg::HDR_FIRST;
            else if (i == 1) d = crc8fc_pkg::HDR_SECOND;
            else if (i == 2) d = n[7:0];
            else if (i == n - 1 && good_crc) d = frame_crc;
         end
         if (i == bad_pos) d = d ^ 8'($urandom_range(1, 255));
         send_beat(d, i == n - 1, 1'b0, '0);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (status_due_q.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // leaves the port selected; the caller idles it
   task automatic csr_access(input logic wr, input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= POLY_ADDR;
      csr_pwdata <= {{(crc8fc_pkg::CSR_DATA_WIDTH-8){1'b0}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (!wr && csr_prdata[7:0] !== value) begin
         $error("crc_polynomial readback: expected %0h, actual %0h", value, csr_prdata[7:0]);
         csr_fail_count++;
      end
      @(negedge clock);
   endtask

   task automatic set_poly(input logic [7:0] value);
      drain();
      csr_access(1'b1, value);
      crc_poly = value;
      csr_access(1'b0, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      poly_settings++;
   endtask

   task automatic random_phase(input logic [7:0] poly, input int unsigned gap,
                               input int unsigned stall);
      int unsigned phase_end;
      set_poly(poly);
      sender_gap_pct = gap;
      stall_pct = stall;
      phase_end = beats_sent + BEATS_PER_PHASE;
      while (beats_sent < phase_end) send_frame(0);
   endtask

   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_left = LONG_HOLD_CYCLES;
         hold_served = hold_requests;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         status_seen[rsp_payload.status]++;
         if (status_due_q.size() == 0) begin
            $error("status beat with none pending: status %0d frame_length %0d",
                   rsp_payload.status, rsp_payload.frame_length);
            fail_count++;
         end else begin
            want = status_due_q.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_payload.status);
               fail_count++;
            end
            if (rsp_payload.frame_length !== want.frame_length) begin
               $error("frame_length: expected %0d, actual %0d",
                      want.frame_length, rsp_payload.frame_length);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      logic [7:0]                  d;
      crc8fc_pkg::rsp_payload_type typed_rsp;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (frame_rows[i]) begin
         d = frame_rows[i].data_byte;
         if (frame_rows[i].use_crc) d = frame_crc;
         if (frame_rows[i].bad_crc) d = frame_crc ^ 8'h01;
         typed_rsp = {frame_rows[i].status, frame_rows[i].frame_length};
         send_beat(d, frame_rows[i].last, frame_rows[i].typed, typed_rsp);
      end

      send_frame(127);
      send_frame(255);
      send_frame(260);
      random_phase(crc8fc_pkg::POLY_RESET, 0, 0);
      random_phase(8'h00, 46, 0);
      random_phase(8'hFF, 0, 46);

      // hold the result side off while single-byte frames keep coming
      drain();
      hold_requests++;
      for (int i = 0; i < 40; i++) send_beat(8'($urandom), 1'b1, 1'b0, '0);
      random_phase(8'h31, 20, 20);
      random_phase(8'($urandom), 0, 0);
      random_phase(8'h1D, 20, 20);

      drain();
      repeat (6) @(posedge clock);
      $display("Sent %0d bytes in %0d frames across %0d polynomial settings.",
               beats_sent, frames_done, poly_settings);
      $display("Statuses seen: ok %0d, short %0d, header %0d, length %0d, crc %0d.",
               status_seen[crc8fc_pkg::ST_OK], status_seen[crc8fc_pkg::ST_SHORT],
               status_seen[crc8fc_pkg::ST_HEADER], status_seen[crc8fc_pkg::ST_LENGTH],
               status_seen[crc8fc_pkg::ST_CRC]);
      if (fail_count == 0 && csr_fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
